/* rtl/gpm_pkg.sv */
// Package for the glob path matcher: word types, codes and character constants.
`default_nettype none

package gpm_pkg;

  localparam int SCNT_W = 27;
  localparam logic [SCNT_W-1:0] SCNT_MAX = {SCNT_W{1'b1}};

  localparam logic [31:0] WORK_LIMIT_RESET = 32'd67108864;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PAT_LONG = 2'd1;
  localparam logic [1:0] ST_WORK     = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_byte;
  } in_word_t;

  typedef struct packed {
    logic       matched;
    logic [1:0] status;
  } out_word_t;

endpackage

`default_nettype wire

/* rtl/glob_path_matcher.sv */
// Glob path matcher top level: pattern store, NFA active set and result register.
//
// Usage. Words arrive on the in_ channel (valid/ready). Each word carries a mode:
// clear the pattern, append a pattern byte, feed one string byte, or end the
// string. Only the end-of-string word gives a result word on the out_ channel,
// holding matched and status (ok, pattern overflowed the store, work limit hit).
// '?' takes one non-slash byte, '*' a run of non-slash bytes, '**' (with an
// optional trailing slash) any run of bytes; a slash just before '**' may match
// nothing when the next byte is not a slash.
// Timing: a word is taken into an input register, then processed (closure of the
// active set, byte step, work check) into the state and the result register, so
// a result is valid from the edge at which its end-of-string word is processed.
// Throughput is one word per cycle; the limit is the combinational closure chain
// over the pattern positions. The input side keeps taking words while a result
// waits, stopping only when an end-of-string word would need the busy output.
// cfg_we writes work_limit at once; only write it while the block is idle.
// Reset (synchronous, rst_n low) empties the pattern, clears the active set,
// marks the next string as fresh and restores work_limit to 2^26.
// A clear or append abandons any string in progress.
`default_nettype none

module glob_path_matcher #(
  parameter int MAX_PATTERN = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  gpm_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output gpm_pkg::out_word_t  out_data,
  input  wire                 cfg_we,
  input  wire  [31:0]         cfg_wdata
);

  import gpm_pkg::*;

  localparam int N   = MAX_PATTERN;
  localparam int CW  = $clog2(N + 1);              // pattern count width
  localparam int PW  = (N > 1) ? $clog2(N) : 1;    // store index width
  localparam int PRW = CW + 1 + SCNT_W + 1;        // work product width
  localparam int CMPW = (PRW > 32) ? PRW : 32;

  // Input register
  logic     s_valid_r;
  in_word_t s_word_r;
  logic     s_go;
  logic     is_end;

  // State
  logic [7:0]        store_r [0:N-1];
  logic [CW-1:0]     pcount_r, pcount_nxt;
  logic              too_long_r, too_long_nxt;
  logic [N:0]        act_r, act_nxt;
  logic              fresh_r, fresh_nxt;
  logic [SCNT_W-1:0] scount_r, scount_nxt;
  logic [31:0]       work_limit_r;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  // Datapath
  logic [N:0]        cur;
  logic [SCNT_W-1:0] scount_eff;
  logic              nslash_b;
  logic              sl_cond;
  logic              is_star    [-4:N+3];
  logic              is_quest   [-4:N+3];
  logic              is_slash   [-4:N+3];
  logic              is_lit_hit [-4:N+3];
  logic              cl         [-4:N];
  logic              store_we;

  logic [CW:0]       n1;
  logic [SCNT_W:0]   sc1;
  logic [PRW-1:0]    prod;
  logic              over_work;

  assign is_end   = (s_word_r.mode == MODE_END);
  assign s_go     = s_valid_r && (!is_end || !out_valid_r || out_ready);
  assign in_ready = !s_valid_r || s_go;

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // A fresh string starts from position 0 with an empty count
  assign cur        = fresh_r ? {{N{1'b0}}, 1'b1} : act_r;
  assign scount_eff = fresh_r ? '0 : scount_r;
  assign nslash_b   = (s_word_r.char_byte != CH_SLASH);
  assign sl_cond    = is_end || nslash_b;

  // Per-position pattern classes, zero outside the loaded pattern
  always_comb begin
    for (int k = -4; k <= N + 3; k++) begin
      is_star[k]    = 1'b0;
      is_quest[k]   = 1'b0;
      is_slash[k]   = 1'b0;
      is_lit_hit[k] = 1'b0;
      if (k >= 0 && k < N) begin
        if (k < int'(pcount_r)) begin
          is_star[k]    = (store_r[k] == CH_STAR);
          is_quest[k]   = (store_r[k] == CH_QUEST);
          is_slash[k]   = (store_r[k] == CH_SLASH);
          is_lit_hit[k] = (store_r[k] != CH_STAR) && (store_r[k] != CH_QUEST) &&
                          (store_r[k] == s_word_r.char_byte);
        end
      end
    end
  end

  // Epsilon closure: every edge spans one to four positions forward, so this
  // is a carry-style OR chain in ascending order.
  always_comb begin
    for (int j = -4; j <= N; j++) begin
      if (j < 0) begin
        cl[j] = 1'b0;
      end else begin
        cl[j] = cur[j]
              | (cl[j-1] & is_star[j-1] & !is_star[j])
              | (cl[j-2] & is_star[j-2] & is_star[j-1] & !is_slash[j])
              | (cl[j-3] & is_star[j-3] & is_star[j-2] & is_slash[j-1])
              | (cl[j-3] & is_slash[j-3] & is_star[j-2] & is_star[j-1] & sl_cond &
                 !is_slash[j])
              | (cl[j-4] & is_slash[j-4] & is_star[j-3] & is_star[j-2] & sl_cond &
                 is_slash[j-1]);
      end
    end
  end

  // Work check: (pattern length + 1) * (string length + 1) against the limit
  assign n1        = {1'b0, pcount_r} + (CW+1)'(1);
  assign sc1       = {1'b0, scount_eff} + (SCNT_W+1)'(1);
  assign prod      = n1 * sc1;
  assign over_work = (pcount_r != '0) &&
                     (CMPW'(prod) > CMPW'(work_limit_r));

  assign store_we = s_go && (s_word_r.mode == MODE_APPEND) && (int'(pcount_r) < N);

  always_comb begin
    pcount_nxt    = pcount_r;
    too_long_nxt  = too_long_r;
    act_nxt       = act_r;
    fresh_nxt     = fresh_r;
    scount_nxt    = scount_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (s_go) begin
      case (s_word_r.mode)
        MODE_CLEAR: begin
          pcount_nxt   = '0;
          too_long_nxt = 1'b0;
          fresh_nxt    = 1'b1;
        end
        MODE_APPEND: begin
          if (int'(pcount_r) < N) begin
            pcount_nxt = pcount_r + CW'(1);
          end else begin
            too_long_nxt = 1'b1;
          end
          fresh_nxt = 1'b1;
        end
        MODE_STRING: begin
          for (int j = 0; j <= N; j++) begin
            act_nxt[j] = (cl[j] & is_star[j] & (is_star[j+1] | nslash_b))
                       | (cl[j-1] & ((is_quest[j-1] & nslash_b) | is_lit_hit[j-1]));
          end
          fresh_nxt  = 1'b0;
          scount_nxt = (scount_eff != SCNT_MAX) ? scount_eff + SCNT_W'(1) : scount_eff;
        end
        MODE_END: begin
          if (too_long_r) begin
            out_word_nxt.matched = 1'b0;
            out_word_nxt.status  = ST_PAT_LONG;
          end else if (over_work) begin
            out_word_nxt.matched = 1'b0;
            out_word_nxt.status  = ST_WORK;
          end else begin
            out_word_nxt.matched = cl[pcount_r];
            out_word_nxt.status  = ST_OK;
          end
          out_valid_nxt = 1'b1;
          fresh_nxt     = 1'b1;
        end
        default: begin
          fresh_nxt = fresh_r;
        end
      endcase
    end
  end

  // Pattern store: written at the fill count, no reset
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[pcount_r[PW-1:0]] <= s_word_r.char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_word_r <= in_data;
    end
    out_word_r <= out_word_nxt;
    if (s_go && s_word_r.mode == MODE_STRING) begin
      scount_r <= scount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      pcount_r     <= '0;
      too_long_r   <= 1'b0;
      act_r        <= '0;
      fresh_r      <= 1'b1;
      work_limit_r <= WORK_LIMIT_RESET;
    end else begin
      s_valid_r   <= in_valid || (s_valid_r && !s_go);
      out_valid_r <= out_valid_nxt;
      pcount_r    <= pcount_nxt;
      too_long_r  <= too_long_nxt;
      act_r       <= act_nxt;
      fresh_r     <= fresh_nxt;
      if (cfg_we) begin
        work_limit_r <= cfg_wdata;
      end
    end
  end

  // Checks
  a_no_match_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.matched && out_word_r.status != ST_OK))
    else $error("match reported with error status");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pcount_r) <= N)
    else $error("pattern count beyond store");

  a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    too_long_r |-> int'(pcount_r) == N)
    else $error("overflow flagged with store not full");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s_go && is_end) |=> out_valid_r)
    else $error("end-of-string word lost its result");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for the glob path matcher: directed and random words against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import gpm_pkg::*;

  localparam int PAT_DEPTH   = 64;
  localparam int CYCLE_LIMIT = 200000;
  // Words with no result may still be in flight once the last verdict is out;
  // the settle wait gives them time to pass through the block.
  localparam int SETTLE_CYCLES = 8;

  // ---------------------------------------------------------------- clock/reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- DUT ports
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  glob_path_matcher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------- bench state
  in_word_t  pending_words [$];   // words waiting to be offered to the block
  out_word_t verdicts_due [$];    // predicted match/status words, oldest first
  int        mismatches = 0;
  int        words_queued = 0;
  int        cycle_count = 0;
  bit        word_taken = 1'b0;   // set at the edge that accepted the current word
  bit        no_idle = 1'b0;      // suppresses random gaps on both sides

  // ---------------------------------------------------------------- predictor
  // Private copy of the matcher state, updated at every accepted word.
  logic [7:0]          pat_mem [PAT_DEPTH];
  int unsigned         pat_len = 0;
  bit                  pat_overflow = 1'b0;
  bit [PAT_DEPTH:0]    live = '0;        // active NFA positions
  bit                  fresh = 1'b1;     // next string byte starts a new string
  logic [SCNT_W-1:0]   str_len = '0;     // saturating string length
  logic [31:0]         limit_copy = WORK_LIMIT_RESET;

  // Reads beyond the pattern read as zero; the NFA never asks for them anyway.
  function automatic logic [7:0] pat_byte(int unsigned i);
    return (i < pat_len) ? pat_mem[i] : 8'h00;
  endfunction

  // Step over an optional slash after a globstar.
  function automatic int unsigned past_slash(int unsigned r);
    return (r < pat_len && pat_byte(r) == CH_SLASH) ? r + 1 : r;
  endfunction

  function automatic bit is_globstar(int unsigned i);
    return pat_byte(i) == CH_STAR && i + 1 < pat_len && pat_byte(i + 1) == CH_STAR;
  endfunction

  // Epsilon moves. All edges point forward, so one ascending sweep is enough.
  function automatic bit [PAT_DEPTH:0] close_set(bit [PAT_DEPTH:0] s, bit at_end,
                                                 logic [7:0] b);
    logic [7:0] c;
    for (int unsigned i = 0; i < pat_len; i++) begin
      if (s[i]) begin
        c = pat_byte(i);
        if (c == CH_STAR) begin
          if (is_globstar(i)) s[past_slash(i + 2)] = 1'b1;
          else s[i + 1] = 1'b1;
        end else if (c == CH_SLASH && i + 2 < pat_len && pat_byte(i + 1) == CH_STAR &&
                     pat_byte(i + 2) == CH_STAR && (at_end || b != CH_SLASH)) begin
          // slash before globstar may vanish unless the next byte is a slash
          s[past_slash(i + 3)] = 1'b1;
        end
      end
    end
    return s;
  endfunction

  task automatic begin_string_if_fresh();
    if (fresh) begin
      live    = '0;
      live[0] = 1'b1;
      str_len = '0;
      fresh   = 1'b0;
    end
  endtask

  task automatic glob_apply(in_word_t w);
    bit [PAT_DEPTH:0] cur;
    bit [PAT_DEPTH:0] nxt;
    logic [7:0]       c;
    logic [63:0]      prod;
    out_word_t        v;
    case (w.mode)
      MODE_CLEAR: begin
        pat_len      = 0;
        pat_overflow = 1'b0;
        fresh        = 1'b1;
      end
      MODE_APPEND: begin
        if (pat_len < PAT_DEPTH) begin
          pat_mem[pat_len] = w.char_byte;
          pat_len++;
        end else begin
          pat_overflow = 1'b1;
        end
        fresh = 1'b1;
      end
      MODE_STRING: begin
        begin_string_if_fresh();
        cur = close_set(live, 1'b0, w.char_byte);
        nxt = '0;
        for (int unsigned i = 0; i < pat_len; i++) begin
          if (cur[i]) begin
            c = pat_byte(i);
            if (c == CH_STAR) begin
              if (is_globstar(i) || w.char_byte != CH_SLASH) nxt[i] = 1'b1;
            end else if (c == CH_QUEST) begin
              if (w.char_byte != CH_SLASH) nxt[i + 1] = 1'b1;
            end else if (w.char_byte == c) begin
              nxt[i + 1] = 1'b1;
            end
          end
        end
        live = nxt;
        if (str_len != SCNT_MAX) str_len++;
      end
      default: begin
        begin_string_if_fresh();
        cur       = close_set(live, 1'b1, 8'h00);
        v.matched = cur[pat_len];
        v.status  = ST_OK;
        if (pat_overflow) begin
          v.status  = ST_PAT_LONG;
          v.matched = 1'b0;
        end else if (pat_len > 0) begin
          prod = (64'(pat_len) + 64'd1) * (64'(str_len) + 64'd1);
          if (prod > 64'(limit_copy)) begin
            v.status  = ST_WORK;
            v.matched = 1'b0;
          end
        end
        fresh = 1'b1;
        verdicts_due.push_back(v);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sampling at the rising edge: DUT outputs change by nonblocking update, so
  // the values read here are the ones that were present at the edge.
  always @(posedge clk) begin
    out_word_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
      $display("tb_top NOT OK");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) begin
        glob_apply(in_data);
        word_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected result word", out_data, 0);
        end else begin
          want = verdicts_due.pop_front();
          if (out_data.matched !== want.matched)
            report_mismatch("matched", out_data.matched, want.matched);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver
  // Inputs move on the falling edge. A word stays put until the edge that takes
  // it; only then may the next one (or a gap) follow.
  always @(negedge clk) begin
    if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (rst_n && pending_words.size() != 0 &&
          (no_idle || $urandom_range(0, 99) >= 19)) begin
        in_valid <= 1'b1;
        in_data  <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, same gap rate.
  always @(negedge clk) begin
    out_ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 19);
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send(logic [1:0] m, logic [7:0] b);
    in_word_t w;
    w.mode      = m;
    w.char_byte = b;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic load_pattern(string p);
    send(MODE_CLEAR, 8'($urandom));
    for (int i = 0; i < p.len(); i++) send(MODE_APPEND, p[i]);
  endtask

  task automatic try_string(string s);
    for (int i = 0; i < s.len(); i++) send(MODE_STRING, s[i]);
    send(MODE_END, 8'($urandom));
  endtask

  // Sender holds back until every verdict is in.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || verdicts_due.size() != 0)
      @(negedge clk);
  endtask

  // Idle point for register writes: drained, plus time for result-less words.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_copy = v;
  endtask

  // Pattern alphabet leans on the metacharacters and slash.
  function automatic logic [7:0] pick_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1:    return CH_STAR;
      2:       return CH_QUEST;
      3, 4:    return CH_SLASH;
      5, 6:    return "a";
      7:       return "b";
      8:       return 8'($urandom);
      default: return "c";
    endcase
  endfunction

  function automatic logic [7:0] pick_string_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return "a";
      3:       return "b";
      4:       return "c";
      5, 6:    return CH_SLASH;
      7:       return CH_STAR;
      default: return 8'($urandom);
    endcase
  endfunction

  // One random sequence: mostly a pattern and a few strings against it, some
  // of them built to match; the rest noise, long patterns that may overflow, and strings
  // broken by a pattern edit.
  task automatic random_sequence();
    logic [7:0] pat_q [$];
    int         kind;
    int         n;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) send(2'($urandom), 8'($urandom));
    end else if (kind < 12) begin
      send(MODE_CLEAR, 8'($urandom));
      repeat ($urandom_range(50, 70)) send(MODE_APPEND, pick_pattern_byte());
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(0, 6)) send(MODE_STRING, pick_string_byte());
        send(MODE_END, 8'($urandom));
      end
    end else begin
      send(MODE_CLEAR, 8'($urandom));
      n = $urandom_range(0, 8);
      repeat (n) pat_q.push_back(pick_pattern_byte());
      foreach (pat_q[k]) send(MODE_APPEND, pat_q[k]);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1) == 0) begin
          // expand the pattern into a string it should accept
          for (int i = 0; i < pat_q.size(); i++) begin
            if (pat_q[i] == CH_STAR && i + 1 < pat_q.size() && pat_q[i + 1] == CH_STAR) begin
              repeat ($urandom_range(0, 3))
                send(MODE_STRING, ($urandom_range(0, 2) == 0) ? CH_SLASH : "a");
              i++;
            end else if (pat_q[i] == CH_STAR) begin
              repeat ($urandom_range(0, 2))
                send(MODE_STRING, ($urandom_range(0, 1) == 0) ? "a" : "c");
            end else if (pat_q[i] == CH_QUEST) begin
              send(MODE_STRING, 8'($urandom_range(0, 46)));
            end else begin
              send(MODE_STRING, pat_q[i]);
            end
          end
        end else begin
          repeat ($urandom_range(0, 10)) send(MODE_STRING, pick_string_byte());
        end
        if ($urandom_range(0, 19) == 0) begin
          // edit mid-string: the partial string is dropped
          send(MODE_APPEND, pick_pattern_byte());
          pat_q.push_back(8'h00);
          pat_q.delete();
        end
        send(MODE_END, 8'($urandom));
      end
    end
  endtask

  task automatic random_words(int count);
    int stop_at;
    stop_at = words_queued + count;
    while (words_queued < stop_at) random_sequence();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pattern vs empty string straight after reset.
    send(MODE_END, 8'hFF);
    send(MODE_STRING, "a");
    send(MODE_END, 8'h00);
    load_pattern("a*b?");
    try_string("axxbq");
    try_string("a/bq");
    load_pattern("**/x");
    try_string("x");
    try_string("a/b/x");
    load_pattern("a/**");
    try_string("a");
    try_string("a/b/c");
    load_pattern("a/**/b");
    try_string("a//b");
    try_string("ab");
    load_pattern("?");
    try_string("/");
    // zero and all-ones bytes are plain literals
    send(MODE_CLEAR, 8'hFF);
    send(MODE_APPEND, 8'h00);
    send(MODE_APPEND, 8'hFF);
    send(MODE_STRING, 8'h00);
    send(MODE_STRING, 8'hFF);
    send(MODE_END, 8'h55);
    // pattern grows mid-string; the string restarts on its next byte
    load_pattern("ab");
    send(MODE_STRING, "a");
    send(MODE_APPEND, "c");
    try_string("abc");
    // store overflow
    send(MODE_CLEAR, 8'h00);
    repeat (PAT_DEPTH + 1) send(MODE_APPEND, "a");
    try_string("a");
    wait_idle();

    // Widest limit.
    write_limit(32'hFFFF_FFFF);
    random_words(70);
    wait_idle();

    // Tightest limit: every non-empty pattern trips the work check.
    write_limit(32'd1);
    random_words(35);
    wait_idle();

    // Middling limit, and a stretch with no gaps on either side.
    write_limit(32'd40);
    no_idle = 1'b1;
    random_words(60);
    wait_idle();
    no_idle = 1'b0;

    // Back to the reset value; sender stalls once until all verdicts land.
    write_limit(WORK_LIMIT_RESET);
    random_words(30);
    wait_drained();
    random_words(25);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0)
      report_mismatch("results never seen", 0, verdicts_due.size());
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
